FILE: rtl/spims_pkg.sv
package spims_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 4;

  localparam logic [BYTE_BITS-1:0] POS_LSB   = 8'h01;
  localparam logic [BYTE_BITS-1:0] POS_MSB   = 8'h80;
  localparam logic [CNT_W-1:0]     FULL_BITS = 4'd8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_IDLE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TRAILING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_BYTE_BITS = 2'd3;

  // Request function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic             clock_idle_high;
    logic             sample_trailing;
    logic             lsb_first;
    logic [CNT_W-1:0] final_byte_bits;
  } cfg_t;

  typedef struct packed {
    logic                 sclk_level;
    logic                 mosi_level;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 byte_done;
    logic                 busy_res;
  } res_t;

endpackage

FILE: rtl/spims_cfg_regs.sv
module spims_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spims_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spims_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output spims_pkg::cfg_t                  cfg
);
  import spims_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_IDLE_HIGH: cfg_nxt.clock_idle_high = cfg_wdata[0];
        REG_SAMPLE_TRAILING: cfg_nxt.sample_trailing = cfg_wdata[0];
        REG_LSB_FIRST:       cfg_nxt.lsb_first       = cfg_wdata[0];
        REG_FINAL_BYTE_BITS: cfg_nxt.final_byte_bits = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_idle_high <= 1'b0;
      cfg_r.sample_trailing <= 1'b0;
      cfg_r.lsb_first       <= 1'b0;
      cfg_r.final_byte_bits <= FULL_BITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/spims_core.sv
module spims_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spims_pkg::cfg_t                  cfg,
  input  logic                             accept,
  input  logic                             func,
  input  logic [spims_pkg::BYTE_BITS-1:0]  tx_byte,
  input  logic                             final_byte,
  input  logic                             miso_level,
  output spims_pkg::res_t                  res
);
  import spims_pkg::*;

  logic [BYTE_BITS-1:0] shift_data_r, shift_data_nxt;
  logic [BYTE_BITS-1:0] bit_select_r, bit_select_nxt;
  logic [CNT_W-1:0]     bits_remaining_r, bits_remaining_nxt;
  logic                 second_half_r, second_half_nxt;
  logic                 active_r, active_nxt;
  logic                 data_out_r, data_out_nxt;

  logic [CNT_W-1:0]     start_count;
  logic [BYTE_BITS-1:0] first_pos;
  logic [BYTE_BITS-1:0] sampled;
  logic                 sclk;
  logic                 done;

  // Pick the bit count and first position for a start request
  always_comb begin
    start_count = FULL_BITS;
    if (final_byte) begin
      start_count = (cfg.final_byte_bits > FULL_BITS) ? FULL_BITS : cfg.final_byte_bits;
    end
    first_pos = cfg.lsb_first ? POS_LSB : POS_MSB;
  end

  // Shift register with the MISO level dropped into the current position
  assign sampled = miso_level ? (shift_data_r | bit_select_r)
                              : (shift_data_r & ~bit_select_r);

  // Next state for one request
  always_comb begin
    shift_data_nxt     = shift_data_r;
    bit_select_nxt     = bit_select_r;
    bits_remaining_nxt = bits_remaining_r;
    second_half_nxt    = second_half_r;
    active_nxt         = active_r;
    data_out_nxt       = data_out_r;
    sclk               = cfg.clock_idle_high;
    done               = 1'b0;
    if (func == FUNC_START) begin
      shift_data_nxt     = tx_byte;
      bit_select_nxt     = first_pos;
      bits_remaining_nxt = start_count;
      second_half_nxt    = 1'b0;
      if (start_count == '0) begin
        active_nxt = 1'b0;
        done       = 1'b1;
      end else begin
        active_nxt   = 1'b1;
        data_out_nxt = |(tx_byte & first_pos);
      end
    end else if (active_r) begin
      if (!second_half_r) begin
        // Leading edge
        sclk            = ~cfg.clock_idle_high;
        second_half_nxt = 1'b1;
        if (!cfg.sample_trailing) begin
          shift_data_nxt = sampled;
        end
      end else begin
        // Trailing edge: advance to the next position
        second_half_nxt    = 1'b0;
        if (cfg.sample_trailing) begin
          shift_data_nxt = sampled;
        end
        bits_remaining_nxt = bits_remaining_r - 1'b1;
        bit_select_nxt     = cfg.lsb_first ? (bit_select_r << 1) : (bit_select_r >> 1);
        if (bits_remaining_nxt == '0) begin
          active_nxt = 1'b0;
          done       = 1'b1;
        end else begin
          data_out_nxt = |(shift_data_nxt & bit_select_nxt);
        end
      end
    end
  end

  // Hold state between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_data_r     <= '0;
      bit_select_r     <= '0;
      bits_remaining_r <= '0;
      second_half_r    <= 1'b0;
      active_r         <= 1'b0;
      data_out_r       <= 1'b0;
    end else if (accept) begin
      shift_data_r     <= shift_data_nxt;
      bit_select_r     <= bit_select_nxt;
      bits_remaining_r <= bits_remaining_nxt;
      second_half_r    <= second_half_nxt;
      active_r         <= active_nxt;
      data_out_r       <= data_out_nxt;
    end
  end

  assign res.sclk_level = sclk;
  assign res.mosi_level = data_out_nxt;
  assign res.rx_byte    = shift_data_nxt;
  assign res.byte_done  = done;
  assign res.busy_res   = active_nxt;

  // A running transfer always has bits left, at most a full byte
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (bits_remaining_r != '0) && (bits_remaining_r <= FULL_BITS))
    else $error("active transfer with bad bit count");

  // The second half only exists inside a transfer
  a_half_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    second_half_r |-> active_r)
    else $error("second half flag set while idle");

  // A tick while idle changes nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == FUNC_TICK && !active_r) |=>
      $stable(shift_data_r) && !active_r && $stable(data_out_r))
    else $error("idle tick changed state");

endmodule

FILE: rtl/spims_out_stage.sv
module spims_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  spims_pkg::res_t  res,
  output logic             out_valid,
  input  logic             out_ready,
  output spims_pkg::res_t  out_res
);
  import spims_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;
  logic load;

  // Take a new request whenever the held result is gone or leaving
  assign in_ready = !out_valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/spi_master_bit_shifter.sv
// SPI master bit shifter, clock modes 0 to 3.
// Input channel (in_valid/in_ready): in_func selects a start request, which
// loads in_tx_byte and picks 8 bits or, when in_final_byte is set, the
// configured final_byte_bits count, or a tick request, which is one half
// bit: the first tick after a start is the leading edge, the next the
// trailing edge. in_miso_level is sampled on the edge chosen by
// sample_trailing. Every request yields exactly one result on the output
// channel (out_valid/out_ready) carrying the line levels, the shift
// register, byte_done on the request that finishes the byte, and busy.
// The output stage registers the result at the edge that accepts the
// request. One request per cycle is taken while the receiver does not stall;
// the single output register is refilled in the same cycle it is drained.
// While the receiver stalls, in_ready drops and the result holds.
// Reset clears the transfer state and sets clock idle low, leading-edge
// sampling, MSB first and a final count of 8. Configuration writes through
// cfg_we/cfg_index/cfg_wdata take effect on the next edge.
module spi_master_bit_shifter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spims_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spims_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [spims_pkg::BYTE_BITS-1:0]  in_tx_byte,
  input  logic                             in_final_byte,
  input  logic                             in_miso_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_sclk_level,
  output logic                             out_mosi_level,
  output logic [spims_pkg::BYTE_BITS-1:0]  out_rx_byte,
  output logic                             out_byte_done,
  output logic                             out_busy_res
);
  import spims_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic accept;

  assign accept = in_valid && in_ready;

  spims_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spims_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .func       (in_func),
    .tx_byte    (in_tx_byte),
    .final_byte (in_final_byte),
    .miso_level (in_miso_level),
    .res        (res)
  );

  spims_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_sclk_level = out_res.sclk_level;
  assign out_mosi_level = out_res.mosi_level;
  assign out_rx_byte    = out_res.rx_byte;
  assign out_byte_done  = out_res.byte_done;
  assign out_busy_res   = out_res.busy_res;

endmodule

FILE: verif/tb_spi_master_bit_shifter.sv
module tb_spi_master_bit_shifter;
  timeunit 1ns;
  timeprecision 1ps;

  import spims_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [BYTE_BITS-1:0] in_tx_byte;
  logic                 in_final_byte;
  logic                 in_miso_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_sclk_level;
  logic                 out_mosi_level;
  logic [BYTE_BITS-1:0] out_rx_byte;
  logic                 out_byte_done;
  logic                 out_busy_res;

  spi_master_bit_shifter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_tx_byte     (in_tx_byte),
    .in_final_byte  (in_final_byte),
    .in_miso_level  (in_miso_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sclk_level (out_sclk_level),
    .out_mosi_level (out_mosi_level),
    .out_rx_byte    (out_rx_byte),
    .out_byte_done  (out_byte_done),
    .out_busy_res   (out_busy_res)
  );

  // Shifter model: configuration and transfer state
  cfg_t                 line_cfg;
  logic [BYTE_BITS-1:0] sh_data;
  logic [BYTE_BITS-1:0] sh_pos;
  logic [CNT_W-1:0]     sh_left;
  logic                 sh_second;
  logic                 sh_active;
  logic                 sh_sclk;
  logic                 sh_mosi;

  // Line states still owed by the block, oldest first
  res_t line_state_q[$];

  int error_count   = 0;
  int useful_sent   = 0;
  bit allow_gaps    = 1'b1;
  bit hold_pending  = 1'b0;
  int hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Write the sampled MISO level into the current bit position
  function automatic void take_miso(logic miso);
    sh_data = miso ? (sh_data | sh_pos) : (sh_data & ~sh_pos);
  endfunction

  function automatic int bits_for(logic fin);
    if (!fin) return FULL_BITS;
    return (line_cfg.final_byte_bits > FULL_BITS) ? FULL_BITS : line_cfg.final_byte_bits;
  endfunction

  // Advance the shifter by one request and return the line state it leaves
  function automatic res_t shift_one_request(logic func, logic [BYTE_BITS-1:0] tx,
                                             logic fin, logic miso);
    res_t             r;
    logic [CNT_W-1:0] count;
    logic             done;
    done = 1'b0;
    if (func == FUNC_START) begin
      count     = CNT_W'(bits_for(fin));
      sh_data   = tx;
      sh_pos    = line_cfg.lsb_first ? POS_LSB : POS_MSB;
      sh_left   = count;
      sh_second = 1'b0;
      sh_sclk   = line_cfg.clock_idle_high;
      if (count == 0) begin
        sh_active = 1'b0;
        done      = 1'b1;
      end else begin
        sh_active = 1'b1;
        sh_mosi   = |(sh_data & sh_pos);
      end
    end else if (sh_active) begin
      if (!sh_second) begin
        sh_sclk = ~line_cfg.clock_idle_high;
        if (!line_cfg.sample_trailing) take_miso(miso);
        sh_second = 1'b1;
      end else begin
        sh_sclk = line_cfg.clock_idle_high;
        if (line_cfg.sample_trailing) take_miso(miso);
        sh_second = 1'b0;
        sh_left   = sh_left - 1'b1;
        sh_pos    = line_cfg.lsb_first ? (sh_pos << 1) : (sh_pos >> 1);
        if (sh_left == 0) begin
          sh_active = 1'b0;
          done      = 1'b1;
        end else begin
          sh_mosi = |(sh_data & sh_pos);
        end
      end
    end else begin
      sh_sclk = line_cfg.clock_idle_high;
    end
    r.sclk_level = sh_sclk;
    r.mosi_level = sh_mosi;
    r.rx_byte    = sh_data;
    r.byte_done  = done;
    r.busy_res   = sh_active;
    return r;
  endfunction

  // Offer one request, hold it until taken, then log its line state
  task automatic send_request(logic func, logic [BYTE_BITS-1:0] tx, logic fin, logic miso);
    @(negedge clk);
    if (allow_gaps && $urandom_range(99) < 22) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_func       = func;
    in_tx_byte    = tx;
    in_final_byte = fin;
    in_miso_level = miso;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_START || sh_active) useful_sent++;
    line_state_q.push_back(shift_one_request(func, tx, fin, miso));
  endtask

  task automatic send_byte(logic [BYTE_BITS-1:0] tx, logic fin, int ticks);
    send_request(FUNC_START, tx, fin, 1'($urandom));
    repeat (ticks) send_request(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Drop valid and wait until every owed line state has come back
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (line_state_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_CLOCK_IDLE_HIGH: begin
        line_cfg.clock_idle_high = val[0];
        if (!sh_active) sh_sclk = val[0];
      end
      REG_SAMPLE_TRAILING: line_cfg.sample_trailing = val[0];
      REG_LSB_FIRST:       line_cfg.lsb_first = val[0];
      REG_FINAL_BYTE_BITS: line_cfg.final_byte_bits = val;
      default: ;
    endcase
  endtask

  // Reprogram all registers once the block is quiet
  task automatic set_mode(logic cih, logic st, logic lsb, logic [CNT_W-1:0] fbb);
    logic [CFG_DAT_W-2:0] junk;
    drain();
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_CLOCK_IDLE_HIGH, {junk, cih});
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_SAMPLE_TRAILING, {junk, st});
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_LSB_FIRST, {junk, lsb});
    write_reg(REG_FINAL_BYTE_BITS, fbb);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly whole bytes, some cut short by a restart, some stray ticks
  task automatic run_random(int n);
    int                   target;
    int                   pick;
    int                   ticks;
    logic [BYTE_BITS-1:0] tx;
    logic                 fin;
    target = useful_sent + n;
    while (useful_sent < target) begin
      pick  = $urandom_range(99);
      fin   = 1'($urandom_range(1));
      tx    = BYTE_BITS'($urandom);
      ticks = 2 * bits_for(fin);
      if (pick < 75) begin
        send_byte(tx, fin, ticks);
      end else if (pick < 87) begin
        send_byte(tx, fin, $urandom_range(ticks));
      end else begin
        repeat ($urandom_range(1, 3))
          send_request(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_idle_tick;
    send_request(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
    send_request(FUNC_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_zero_count;
    set_mode(1'b0, 1'b0, 1'b0, 4'd0);
    send_request(FUNC_START, 8'hC3, 1'b1, 1'b0);
  endtask

  task automatic test_short_byte;
    set_mode(1'b1, 1'b1, 1'b1, 4'd2);
    send_request(FUNC_START, 8'hFF, 1'b1, 1'b1);
    repeat (4) send_request(FUNC_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_restart_while_busy;
    set_mode(1'b0, 1'b1, 1'b0, 4'd1);
    send_request(FUNC_START, 8'h00, 1'b0, 1'b0);
    repeat (3) send_request(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
    send_request(FUNC_START, 8'h5A, 1'b1, 1'b0);
    repeat (2) send_request(FUNC_TICK, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_idle_level_change;
    set_mode(1'b1, 1'b0, 1'b0, 4'd15);
    send_request(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    set_mode(1'b0, 1'b0, 1'b1, 4'd15);
    send_request(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_mode_sweep;
    set_mode(1'b0, 1'b0, 1'b0, 4'd8);
    run_random(90);
    set_mode(1'b1, 1'b1, 1'b1, 4'd1);
    run_random(90);
    set_mode(1'b0, 1'b1, 1'b1, 4'd15);
    run_random(90);
    set_mode(1'b1, 1'b0, 1'b0, 4'd9);
    run_random(90);
    repeat (2) begin
      set_mode(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
      run_random(90);
    end
  endtask

  task automatic test_back_to_back;
    set_mode(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom_range(0, 8)));
    allow_gaps = 1'b0;
    run_random(90);
    allow_gaps = 1'b1;
  endtask

  task automatic test_output_stall;
    set_mode(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom_range(1, 8)));
    hold_pending = 1'b1;
    run_random(90);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(allow_gaps && $urandom_range(99) < 22);
      end
    end
  end

  // Compare each accepted result against the oldest owed line state
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_state_q.size() == 0) begin
        report_mismatch("result with nothing owed", out_rx_byte, 0);
      end else begin
        want = line_state_q.pop_front();
        if (out_sclk_level !== want.sclk_level)
          report_mismatch("sclk_level", out_sclk_level, want.sclk_level);
        if (out_mosi_level !== want.mosi_level)
          report_mismatch("mosi_level", out_mosi_level, want.mosi_level);
        if (out_rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", out_rx_byte, want.rx_byte);
        if (out_byte_done !== want.byte_done)
          report_mismatch("byte_done", out_byte_done, want.byte_done);
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", out_busy_res, want.busy_res);
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_CLOCK_IDLE_HIGH;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_func       = FUNC_START;
    in_tx_byte    = '0;
    in_final_byte = 1'b0;
    in_miso_level = 1'b0;
    line_cfg      = '{clock_idle_high: 1'b0, sample_trailing: 1'b0,
                      lsb_first: 1'b0, final_byte_bits: FULL_BITS};
    sh_data       = '0;
    sh_pos        = '0;
    sh_left       = '0;
    sh_second     = 1'b0;
    sh_active     = 1'b0;
    sh_sclk       = 1'b0;
    sh_mosi       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_tick();
    test_zero_count();
    test_short_byte();
    test_restart_while_busy();
    test_idle_level_change();
    test_mode_sweep();
    test_back_to_back();
    test_output_stall();

    drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
